@@ design/edps_pkg.sv @@
// shared constants and types for the envelope derivative peak slicer
package edps_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int COEFF_BITS  = 17;
  localparam int DERIV_BITS  = 32;
  localparam int SUM_BITS    = 48;
  localparam int POS_BITS    = 17;
  localparam int CFG_BITS    = 17;
  localparam int IDX_BITS    = 3;

  localparam logic [COEFF_BITS-1:0] ONE_Q16 = 17'h10000;

  // command codes
  localparam logic [1:0] CMD_BEGIN  = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_DETECT = 2'd2;
  localparam logic [1:0] CMD_SLICE  = 2'd3;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_ATTACK   = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_RELEASE  = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_SENS     = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_HOLDOFF  = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_RSTART   = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_REND     = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_CHANNELS = 3'd6;

  typedef logic [DERIV_BITS-1:0] deriv_t;

  // saturate a Q1.16 coefficient to one
  function automatic logic [COEFF_BITS-1:0] sat_coeff(input logic [COEFF_BITS-1:0] c);
    sat_coeff = (c > ONE_Q16) ? ONE_Q16 : c;
  endfunction

  // magnitude of a signed sample
  function automatic logic [SAMPLE_BITS:0] magnitude(input logic [SAMPLE_BITS-1:0] s);
    if (s[SAMPLE_BITS-1]) begin
      magnitude = (ONE_Q16 << (SAMPLE_BITS - 16)) - {1'b0, s};
    end else begin
      magnitude = {1'b0, s};
    end
  endfunction

endpackage

@@ design/edps_dmem.sv @@
// derivative store: one write port, one read port with registered data
module edps_dmem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  edps_pkg::deriv_t       wr_data,
  input  logic [AW-1:0]          rd_addr,
  output edps_pkg::deriv_t       rd_data
);
  import edps_pkg::*;

  deriv_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/edps_div.sv @@
// restoring divider, one quotient bit a cycle
module edps_div #(
  parameter int VW = 17
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [edps_pkg::SUM_BITS-1:0] dividend,
  input  logic [VW-1:0]                 divisor,
  output logic                          done,
  output logic [edps_pkg::SUM_BITS-1:0] quotient
);
  import edps_pkg::*;

  localparam int CNTW = $clog2(SUM_BITS + 1);

  logic            running;
  logic [CNTW-1:0] count;
  logic [VW:0]     rem;
  logic [VW-1:0]   dvs;
  logic [VW+1:0]   trial;
  logic [VW:0]     shifted;

  // next partial remainder
  always_comb begin
    shifted = {rem[VW-1:0], quotient[SUM_BITS-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running  <= 1'b1;
        count    <= CNTW'(SUM_BITS);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (running) begin
        // shift in a dividend bit and try to subtract
        if (!trial[VW+1]) begin
          rem      <= trial[VW:0];
          quotient <= {quotient[SUM_BITS-2:0], 1'b1};
        end else begin
          rem      <= shifted;
          quotient <= {quotient[SUM_BITS-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CNTW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/envelope_derivative_peak_slicer.sv @@
// Envelope derivative peak slicer: a load passes through S_LOAD, begin acts from idle, detect
// runs S_DIV (noise floor divider), S_MUL and S_THR; the next slice needs no other state when
// no scan is needed, else S_PRIME then S_SCAN (one derivative store read per scanned derivative).
// A result strobe follows the accepting or last scan cycle; the receiver cannot stall.
// Synchronous reset clears configuration, control and statistics; the derivative store is not cleared.
module envelope_derivative_peak_slicer #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        command,
  input  logic [edps_pkg::SAMPLE_BITS-1:0]  left_sample,
  input  logic [edps_pkg::SAMPLE_BITS-1:0]  right_sample,
  input  logic                              cfg_write,
  input  logic [edps_pkg::IDX_BITS-1:0]     cfg_index,
  input  logic [edps_pkg::CFG_BITS-1:0]     cfg_data,
  output logic                              result_valid,
  output logic                              slice_valid,
  output logic [16:0]                       slice_start,
  output logic [16:0]                       slice_end,
  output logic                              last_slice
);
  import edps_pkg::*;

  localparam int AW = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int XW = (CW > 17) ? CW : 17;
  localparam int LW = XW + 2;
  localparam logic [XW-1:0] MAXV = XW'(MAX_SAMPLES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_THR   = 3'd4;
  localparam logic [2:0] S_PRIME = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;

  logic [2:0] state;

  // configuration registers
  logic [COEFF_BITS-1:0] attack_coeff, release_coeff, sensitivity;
  logic [15:0]           holdoff_samples;
  logic [16:0]           range_start, range_end;
  logic [1:0]            channel_count;

  // analysis state
  logic [31:0]           envelope_value;
  logic [XW-1:0]         sample_count;
  deriv_t                max_derivative;
  logic [SUM_BITS-1:0]   positive_sum;
  logic [XW-1:0]         positive_count;
  deriv_t                threshold_value;
  logic [XW-1:0]         scan_index, scan_end, current_slice_start;
  logic signed [LW-1:0]  last_onset;
  logic [15:0]           scan_holdoff;
  logic                  slicing_done, onsets_enabled;
  logic [COEFF_BITS-1:0] scan_sens;

  // shared multiplier
  logic [COEFF_BITS-1:0] mul_a;
  logic [31:0]           mul_b;
  logic [48:0]           product;
  logic                  up;
  deriv_t                diff_span;

  // memory ports
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  deriv_t        rd_data, dp;

  // divider
  logic                 div_go;
  logic                 div_done;
  logic [SUM_BITS-1:0]  quotient;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // rectified input
  logic [SAMPLE_BITS:0] mag_l, mag_r;
  logic [31:0]          x_in;
  always_comb begin
    mag_l = magnitude(left_sample);
    mag_r = magnitude(right_sample);
    if (channel_count == 2'd2) begin
      x_in = 32'({1'b0, mag_l} + {1'b0, mag_r}) << 15;
    end else begin
      x_in = 32'(mag_l) << 16;
    end
  end

  // multiplier operands
  always_comb begin
    if (state == S_IDLE) begin
      if (x_in > envelope_value) begin
        mul_a = sat_coeff(attack_coeff);
        mul_b = x_in - envelope_value;
      end else begin
        mul_a = sat_coeff(release_coeff);
        mul_b = envelope_value - x_in;
      end
    end else begin
      mul_a = scan_sens;
      mul_b = diff_span;
    end
  end

  // envelope step and derivative
  logic [31:0]         env_step, env_new;
  deriv_t              d_new;
  logic [SUM_BITS:0]   sum_ext;
  always_comb begin
    env_step = product[47:16];
    env_new  = up ? (envelope_value + env_step) : (envelope_value - env_step);
    d_new    = (sample_count != '0 && up) ? env_step : '0;
    sum_ext  = {1'b0, positive_sum} + (SUM_BITS + 1)'(d_new);
  end

  // detect clamp of the range
  logic [XW-1:0] rs_c, re_c, re_lim;
  always_comb begin
    rs_c   = (XW'(range_start) > sample_count) ? sample_count : XW'(range_start);
    re_lim = (XW'(range_end) > sample_count) ? sample_count : XW'(range_end);
    re_c   = (re_lim < rs_c) ? rs_c : re_lim;
  end

  // noise floor
  deriv_t noise;
  always_comb begin
    if (positive_count == '0) begin
      noise = '0;
    end else if (quotient > SUM_BITS'(max_derivative)) begin
      noise = max_derivative;
    end else begin
      noise = quotient[31:0];
    end
  end

  // onset test on the derivative just read
  logic                 hit;
  logic [XW-1:0]        idx_next;
  logic signed [LW-1:0] gap;
  always_comb begin
    idx_next = scan_index + 1'b1;
    gap      = $signed({2'b00, scan_index}) - last_onset;
    hit      = (rd_data > threshold_value) && (rd_data >= dp) &&
               (gap >= $signed(LW'(scan_holdoff)));
  end

  // read address
  always_comb begin
    case (state)
      S_PRIME: rd_addr = scan_index[AW-1:0];
      S_SCAN:  rd_addr = idx_next[AW-1:0];
      default: rd_addr = AW'(scan_index - 1'b1);
    endcase
  end

  assign wr_en = (state == S_LOAD);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coeff    <= 17'd1351;
      release_coeff   <= 17'd27;
      sensitivity     <= 17'd32768;
      holdoff_samples <= '0;
      range_start     <= '0;
      range_end       <= 17'h10000;
      channel_count   <= 2'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ATTACK:   attack_coeff    <= cfg_data;
        REG_RELEASE:  release_coeff   <= cfg_data;
        REG_SENS:     sensitivity     <= cfg_data;
        REG_HOLDOFF:  holdoff_samples <= cfg_data[15:0];
        REG_RSTART:   range_start     <= cfg_data;
        REG_REND:     range_end       <= cfg_data;
        REG_CHANNELS: channel_count   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    product <= mul_a * mul_b;
    if (state == S_IDLE) begin
      up <= (x_in > envelope_value);
    end
    if (state == S_DIV) begin
      diff_span <= max_derivative - noise;
    end
    if (state == S_PRIME || state == S_SCAN) begin
      dp <= rd_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      envelope_value      <= '0;
      sample_count        <= '0;
      max_derivative      <= '0;
      positive_sum        <= '0;
      positive_count      <= '0;
      threshold_value     <= '0;
      scan_index          <= '0;
      last_onset          <= '0;
      current_slice_start <= '0;
      slicing_done        <= 1'b1;
      scan_end            <= '0;
      scan_holdoff        <= '0;
      onsets_enabled      <= 1'b0;
      scan_sens           <= '0;
      div_go              <= 1'b0;
      result_valid        <= 1'b0;
      slice_valid         <= 1'b0;
      slice_start         <= '0;
      slice_end           <= '0;
      last_slice          <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      div_go       <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (command)
              CMD_BEGIN: begin
                envelope_value <= '0;
                sample_count   <= '0;
                max_derivative <= '0;
                positive_sum   <= '0;
                positive_count <= '0;
                slicing_done   <= 1'b1;
              end
              CMD_SAMPLE: begin
                if (sample_count < MAXV) begin
                  state <= S_LOAD;
                end
              end
              CMD_DETECT: begin
                scan_sens           <= sat_coeff(sensitivity);
                onsets_enabled      <= (sensitivity != '0);
                scan_holdoff        <= holdoff_samples;
                scan_end            <= re_c;
                scan_index          <= (rs_c < XW'(1)) ? XW'(1) : rs_c;
                last_onset          <= $signed({2'b00, rs_c}) - $signed(LW'(holdoff_samples));
                current_slice_start <= rs_c;
                slicing_done        <= (rs_c == re_c);
                div_go              <= 1'b1;
                state               <= S_DIV;
              end
              default: begin
                if (slicing_done) begin
                  result_valid <= 1'b1;
                  slice_valid  <= 1'b0;
                  slice_start  <= '0;
                  slice_end    <= '0;
                  last_slice   <= 1'b0;
                end else if (!onsets_enabled || scan_index >= scan_end) begin
                  result_valid <= 1'b1;
                  slice_valid  <= 1'b1;
                  slice_start  <= current_slice_start[16:0];
                  slice_end    <= scan_end[16:0];
                  last_slice   <= 1'b1;
                  slicing_done <= 1'b1;
                end else begin
                  state <= S_PRIME;
                end
              end
            endcase
          end
        end
        S_LOAD: begin
          // write back the envelope and statistics
          envelope_value <= env_new;
          if (d_new > max_derivative) begin
            max_derivative <= d_new;
          end
          if (d_new != '0) begin
            positive_sum   <= sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
            positive_count <= positive_count + 1'b1;
          end
          sample_count <= sample_count + 1'b1;
          state        <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_THR;
        end
        S_THR: begin
          threshold_value <= max_derivative - product[47:16];
          state           <= S_IDLE;
        end
        S_PRIME: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          // one derivative per cycle
          scan_index <= idx_next;
          if (hit) begin
            last_onset <= $signed({2'b00, scan_index});
          end
          if (hit && scan_index > current_slice_start) begin
            result_valid        <= 1'b1;
            slice_valid         <= 1'b1;
            slice_start         <= current_slice_start[16:0];
            slice_end           <= scan_index[16:0];
            last_slice          <= 1'b0;
            current_slice_start <= scan_index;
            state               <= S_IDLE;
          end else if (idx_next >= scan_end) begin
            result_valid <= 1'b1;
            slice_valid  <= 1'b1;
            slice_start  <= current_slice_start[16:0];
            slice_end    <= scan_end[16:0];
            last_slice   <= 1'b1;
            slicing_done <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  edps_dmem #(
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_dmem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (sample_count[AW-1:0]),
    .wr_data (d_new),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  edps_div #(
    .VW (XW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (positive_sum),
    .divisor  (positive_count),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule
